>>> src/psod_pkg.sv
// ----------------------------------------------------------------------------
// psod_pkg - shared types and constants for the PDF string object decoder
// Request and result structs, decoder state, character codes and classifiers.
// ----------------------------------------------------------------------------
`default_nettype none

package psod_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } psod_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       object_done;
        logic [1:0] object_kind;
        logic       unterminated;
        logic       last;
    } psod_result_t;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_LT   = 3'd1;
    localparam logic [2:0] MODE_HEX  = 3'd2;
    localparam logic [2:0] MODE_LIT  = 3'd3;
    localparam logic [2:0] MODE_SKIP = 3'd4;

    localparam logic [1:0] KIND_SKIP = 2'd0;
    localparam logic [1:0] KIND_HEX  = 2'd1;
    localparam logic [1:0] KIND_LIT  = 2'd2;
    localparam logic [1:0] KIND_DICT = 2'd3;

    localparam logic ITEM_DATA = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic       escape_pending;
        logic       cr_continuation;
        logic [7:0] octal_value;
        logic [1:0] octal_count;
        logic [3:0] high_nibble;
        logic [1:0] nibble_flags;   // bit0 nibble pending, bit1 it was a hex digit
    } psod_state_t;

    localparam int QDEPTH = 4;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LFF   = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LTT   = 8'h74;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b >= CH_HT && b <= CH_CR);
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_7);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LFF)
            || (b >= CH_UA && b <= CH_UF);
    endfunction

    // letters have low nibble 1..6 in both cases
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (b <= CH_9)
            v = b[3:0];
        else
            v = b[3:0] + 4'd9;
        return v;
    endfunction

    function automatic psod_result_t mk_result(
        input logic [7:0] ob,
        input logic       bv,
        input logic       done,
        input logic [1:0] kd,
        input logic       unt
    );
        psod_result_t r;
        r.out_byte     = ob;
        r.byte_valid   = bv;
        r.object_done  = done;
        r.object_kind  = kd;
        r.unterminated = unt;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/psod_decode.sv
// ----------------------------------------------------------------------------
// psod_decode - one-byte decode step
// Next state and up to two results for one request, from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module psod_decode
    import psod_pkg::*;
#(
    parameter int MAX_DEPTH = 255,
    localparam int DW = $clog2(MAX_DEPTH + 1)
) (
    input  psod_item_t   item,
    input  psod_state_t  state,
    input  logic [DW-1:0] depth,
    output psod_state_t  state_next,
    output logic [DW-1:0] depth_next,
    output logic [1:0]   push_n,
    output psod_result_t res0,
    output psod_result_t res1
);

    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
    localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

    psod_state_t  st;
    logic [DW-1:0] dep;
    logic [1:0]   n;
    psod_result_t r [2];
    logic [7:0]   b;
    logic         do_hex;
    logic         do_idle;
    logic         cont;
    logic         hok;
    logic [3:0]   hv;

    always_comb
    begin
        st      = state;
        dep     = depth;
        n       = 2'd0;
        r[0]    = '0;
        r[1]    = '0;
        b       = item.data_byte;
        do_hex  = 1'b0;
        do_idle = 1'b0;
        cont    = 1'b1;
        hok     = is_hex(b);
        hv      = hex_val(b);

        if (item.kind == ITEM_END)
        begin
            unique case (st.mode)
                MODE_LT:
                begin
                    r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_HEX, 1'b1);
                    n = n + 2'd1;
                end
                MODE_HEX:
                begin
                    if (st.nibble_flags == 2'b11)
                    begin
                        r[n[0]] = mk_result({st.high_nibble, 4'h0}, 1'b1, 1'b0, KIND_HEX, 1'b0);
                        n = n + 2'd1;
                    end
                    r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_HEX, 1'b1);
                    n = n + 2'd1;
                end
                MODE_LIT:
                begin
                    if (st.octal_count != 2'd0)
                    begin
                        r[n[0]] = mk_result(st.octal_value, 1'b1, 1'b0, KIND_LIT, 1'b0);
                        n = n + 2'd1;
                    end
                    r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_LIT, 1'b1);
                    n = n + 2'd1;
                end
                MODE_SKIP:
                begin
                    r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_SKIP, 1'b1);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            st  = '0;
            dep = '0;
        end
        else
        begin
            unique case (st.mode)
                MODE_LT:
                begin
                    if (b == CH_LT)
                    begin
                        r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_DICT, 1'b0);
                        n   = n + 2'd1;
                        st  = '0;
                        dep = '0;
                    end
                    else
                    begin
                        st.mode = MODE_HEX;
                        do_hex  = 1'b1;
                    end
                end
                MODE_HEX:
                    do_hex = 1'b1;
                MODE_LIT:
                begin
                    if (st.octal_count != 2'd0)
                    begin
                        if (is_octal(b))
                        begin
                            st.octal_value = {st.octal_value[4:0], b[2:0]};
                            st.octal_count = st.octal_count + 2'd1;
                            if (st.octal_count == 2'd3)
                            begin
                                r[n[0]] = mk_result(st.octal_value, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                n = n + 2'd1;
                                st.octal_value = '0;
                                st.octal_count = '0;
                            end
                            cont = 1'b0;
                        end
                        else
                        begin
                            r[n[0]] = mk_result(st.octal_value, 1'b1, 1'b0, KIND_LIT, 1'b0);
                            n = n + 2'd1;
                            st.octal_value = '0;
                            st.octal_count = '0;
                        end
                    end
                    if (cont && st.cr_continuation)
                    begin
                        st.cr_continuation = 1'b0;
                        if (b == CH_LF)
                            cont = 1'b0;
                    end
                    if (cont && st.escape_pending)
                    begin
                        st.escape_pending = 1'b0;
                        cont = 1'b0;
                        unique case (b)
                            CH_LN:
                            begin
                                r[n[0]] = mk_result(CH_LF, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                n = n + 2'd1;
                            end
                            CH_LR:
                            begin
                                r[n[0]] = mk_result(CH_CR, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                n = n + 2'd1;
                            end
                            CH_LTT:
                            begin
                                r[n[0]] = mk_result(CH_HT, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                n = n + 2'd1;
                            end
                            CH_LB:
                            begin
                                r[n[0]] = mk_result(CH_BS, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                n = n + 2'd1;
                            end
                            CH_LFF:
                            begin
                                r[n[0]] = mk_result(CH_FF, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                n = n + 2'd1;
                            end
                            CH_CR:
                                st.cr_continuation = 1'b1;
                            CH_LF:
                            begin
                            end
                            default:
                            begin
                                if (is_octal(b))
                                begin
                                    st.octal_value = {5'd0, b[2:0]};
                                    st.octal_count = 2'd1;
                                end
                                else
                                begin
                                    r[n[0]] = mk_result(b, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                    n = n + 2'd1;
                                end
                            end
                        endcase
                    end
                    if (cont)
                    begin
                        if (b == CH_BSL)
                            st.escape_pending = 1'b1;
                        else if (b == CH_LPAR)
                        begin
                            r[n[0]] = mk_result(b, 1'b1, 1'b0, KIND_LIT, 1'b0);
                            n = n + 2'd1;
                            if (dep < DEPTH_MAX)
                                dep = dep + DEPTH_ONE;
                        end
                        else if (b == CH_RPAR)
                        begin
                            if (dep != '0)
                                dep = dep - DEPTH_ONE;
                            if (dep != '0)
                            begin
                                r[n[0]] = mk_result(b, 1'b1, 1'b0, KIND_LIT, 1'b0);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_LIT, 1'b0);
                                n   = n + 2'd1;
                                st  = '0;
                                dep = '0;
                            end
                        end
                        else
                        begin
                            r[n[0]] = mk_result(b, 1'b1, 1'b0, KIND_LIT, 1'b0);
                            n = n + 2'd1;
                        end
                    end
                end
                MODE_SKIP:
                begin
                    if (is_ws(b) || b == CH_SLASH)
                    begin
                        r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_SKIP, 1'b0);
                        n       = n + 2'd1;
                        st      = '0;
                        dep     = '0;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    st      = '0;
                    dep     = '0;
                    do_idle = 1'b1;
                end
            endcase

            if (do_hex)
            begin
                if (b == CH_GT)
                begin
                    if (st.nibble_flags == 2'b11)
                    begin
                        r[n[0]] = mk_result({st.high_nibble, 4'h0}, 1'b1, 1'b0, KIND_HEX, 1'b0);
                        n = n + 2'd1;
                    end
                    r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_HEX, 1'b0);
                    n   = n + 2'd1;
                    st  = '0;
                    dep = '0;
                end
                else if (!is_ws(b))
                begin
                    if (!st.nibble_flags[0])
                    begin
                        st.nibble_flags = {hok, 1'b1};
                        st.high_nibble  = hok ? hv : 4'h0;
                    end
                    else
                    begin
                        if (st.nibble_flags[1] && hok)
                        begin
                            r[n[0]] = mk_result({st.high_nibble, hv}, 1'b1, 1'b0, KIND_HEX, 1'b0);
                            n = n + 2'd1;
                        end
                        st.nibble_flags = 2'b00;
                        st.high_nibble  = 4'h0;
                    end
                end
            end

            if (do_idle)
            begin
                if (b == CH_LT)
                    st.mode = MODE_LT;
                else if (b == CH_LPAR)
                begin
                    st.mode = MODE_LIT;
                    dep     = DEPTH_ONE;
                end
                else if (is_ws(b) || b == CH_SLASH)
                begin
                    r[n[0]] = mk_result(8'h00, 1'b0, 1'b1, KIND_SKIP, 1'b0);
                    n = n + 2'd1;
                end
                else
                    st.mode = MODE_SKIP;
            end
        end

        if (n == 2'd1)
            r[0].last = 1'b1;
        else if (n == 2'd2)
            r[1].last = 1'b1;

        state_next = st;
        depth_next = dep;
        push_n     = n;
        res0       = r[0];
        res1       = r[1];
    end

endmodule

`default_nettype wire

>>> src/psod_result_queue.sv
// ----------------------------------------------------------------------------
// psod_result_queue - result buffer
// Small register queue taking up to two results a cycle, one out per cycle while result_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module psod_result_queue
    import psod_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   push_n,
    input  psod_result_t push0,
    input  psod_result_t push1,
    output logic         room,
    output logic         result_valid,
    input  logic         result_stall,
    output psod_result_t result
);

    localparam int QPW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    psod_result_t    entry_reg [QDEPTH];
    logic [QPW-1:0]  wr_ptr_reg;
    logic [QPW-1:0]  wr_ptr_next;
    logic [QPW-1:0]  rd_ptr_reg;
    logic [QPW-1:0]  rd_ptr_next;
    logic [QCW-1:0]  count_reg;
    logic [QCW-1:0]  count_next;
    logic [QPW-1:0]  wr_ptr_plus1;
    logic            pop;

    assign result_valid = (count_reg != '0);
    assign result       = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // room for the worst case of two results
    assign room         = (count_reg <= QCW'(QDEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + QPW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPW'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + QPW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCW'(push_n) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_n == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

endmodule

`default_nettype wire

>>> src/pdf_string_object_decoder.sv
// ----------------------------------------------------------------------------
// pdf_string_object_decoder - PDF literal and hex string decoder
// Decodes a byte stream into string bytes and end-of-object marks.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+--------------------------------
//  request  | item_valid   | item_stall   | item   (kind, data_byte)
//  result   | result_valid | result_stall | result (out_byte .. last)
//
//  One request per cycle while item_stall is low; a request giving two results
//  uses the single result port for each of them, so that port sets the rate.
//  A taken request passes the input register, decode and the result queue
//  registers before its results are on the port.
//  Reset clears the input stage, the decoder state and the result queue.
//  item_stall rises while a held request waits for room for two results.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_string_object_decoder
    import psod_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  psod_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output psod_result_t result
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic          stage_valid_reg;
    logic          stage_valid_next;
    psod_item_t    stage_item_reg;
    psod_state_t   state_reg;
    psod_state_t   state_next;
    psod_state_t   state_dec;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [DW-1:0] depth_dec;
    logic [1:0]    push_n_dec;
    logic [1:0]    push_n;
    psod_result_t  res0;
    psod_result_t  res1;
    logic          room;
    logic          fire;
    logic          accept;

    assign fire       = stage_valid_reg && room;
    assign item_stall = stage_valid_reg && !fire;
    assign accept     = item_valid && !item_stall;
    assign push_n     = fire ? push_n_dec : 2'd0;

    psod_decode #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_decode (
        .item       (stage_item_reg),
        .state      (state_reg),
        .depth      (depth_reg),
        .state_next (state_dec),
        .depth_next (depth_dec),
        .push_n     (push_n_dec),
        .res0       (res0),
        .res1       (res1)
    );

    psod_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_n       (push_n),
        .push0        (res0),
        .push1        (res1),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always_comb
    begin
        stage_valid_next = accept ? 1'b1 : (fire ? 1'b0 : stage_valid_reg);
        state_next       = fire ? state_dec : state_reg;
        depth_next       = fire ? depth_dec : depth_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            state_reg       <= '0;
            depth_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            state_reg       <= state_next;
            depth_reg       <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_item_reg <= item;
    end

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stage_item_reg.kind == ITEM_END)
            |=> (state_reg == '0 && depth_reg == '0))
        else $error("end of data left decoder state behind");

    a_depth_only_in_literal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode != MODE_LIT) |-> (depth_reg == '0))
        else $error("nesting depth nonzero outside a literal string");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && push_n_dec == 2'd2) |-> (res1.last && !res0.last))
        else $error("last mark not on the final result of a request");

    a_stall_means_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (stage_valid_reg && !room))
        else $error("request stalled without a held request");

endmodule

`default_nettype wire
